/* rtl/core/apc_pkg.sv */
// shared types and constants for the alarm panel
package apc_pkg;

  // alarm modes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_ARMED = 2'd1;
  localparam logic [1:0] MODE_TRIG  = 2'd2;
  localparam logic [1:0] MODE_LEARN = 2'd3;

  // classification of a poll
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_CODE   = 2'd1;
  localparam logic [1:0] KIND_BUTTON = 2'd2;
  localparam logic [1:0] KIND_SENSOR = 2'd3;

  // beep events
  localparam logic [1:0] BEEP_NONE   = 2'd0;
  localparam logic [1:0] BEEP_ARM    = 2'd1;
  localparam logic [1:0] BEEP_DISARM = 2'd2;

  // register indexes on the config port
  localparam logic [1:0] REG_SENSOR_ENABLE = 2'd0;
  localparam logic [1:0] REG_SLOW_BLINK    = 2'd1;
  localparam logic [1:0] REG_FAST_BLINK    = 2'd2;

  // register reset values
  localparam logic [7:0]  SENSOR_ENABLE_RST = 8'd1;
  localparam logic [15:0] SLOW_BLINK_RST    = 16'd700;
  localparam logic [15:0] FAST_BLINK_RST    = 16'd200;

  localparam int          APB_ADDR_W = 4;
  localparam int          APB_DATA_W = 32;

  // configuration register contents
  typedef struct packed {
    logic [7:0]  sensor_enable;
    logic [15:0] slow_blink_ms;
    logic [15:0] fast_blink_ms;
  } cfg_t;

  // control part of a search token moving down the code chain
  typedef struct packed {
    logic vld;
    logic hit;
  } tok_ctl_t;

endpackage

/* rtl/core/apc_if.sv */
// valid/ready channels for panel input items and result items

interface apc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  elapsed_ms;
  logic        rf_valid;
  logic [31:0] rf_code;
  logic        button_pressed;
  logic [7:0]  sensor_lines;

  modport source (
    output valid, command, elapsed_ms, rf_valid, rf_code, button_pressed, sensor_lines,
    input  ready
  );
  modport sink (
    input  valid, command, elapsed_ms, rf_valid, rf_code, button_pressed, sensor_lines,
    output ready
  );
endinterface

interface apc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       green_led;
  logic       red_led;
  logic       siren;
  logic [1:0] beep_count;
  logic [1:0] signal_kind;
  logic       code_learned;
  logic       table_full;

  modport source (
    output valid, mode, green_led, red_led, siren, beep_count, signal_kind,
           code_learned, table_full,
    input  ready
  );
  modport sink (
    input  valid, mode, green_led, red_led, siren, beep_count, signal_kind,
           code_learned, table_full,
    output ready
  );
endinterface

/* rtl/core/alarm_panel_with_code_learning_top.sv */
// top level of the alarm panel with remote code learning
//
// in_i takes one item at a time: a poll (command 0) of elapsed time, remote
// code, learn button and active-low sensor lines, or a preload (command 1)
// of a code into the table. out_o gives exactly one result item per input
// item: mode, led and siren levels, beep event, signal class and table flags.
// The apb port writes sensor_enable, slow_blink_ms and fast_blink_ms at byte
// addresses 0, 4 and 8; write them only while the panel is idle.
// A poll with rf_valid set sends its code down a chain of MAX_CODES cells,
// one cell per cycle, and its final update follows once the token leaves
// the last cell. Preloads and polls without a code go straight to the
// final update. in_i is ready again in the cycle after a result is
// loaded, so a new item is taken only once the last one is through.
// The result sits in an output register; while the receiver stalls, the
// next item is still accepted and searched, and only its final update waits
// for the register to drain.
// Reset puts the panel in off mode with an empty table, leds and siren low,
// the blink timer at zero and the registers at 1, 700 and 200.
module alarm_panel_with_code_learning_top import apc_pkg::*; #(
  parameter int MAX_CODES    = 16,
  parameter int CODE_BITS    = 32,
  parameter int SENSOR_COUNT = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  apc_in_if.sink                in_i,
  apc_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CW    = (CODE_BITS < 32) ? CODE_BITS : 32;
  localparam int SW    = (SENSOR_COUNT < 8) ? SENSOR_COUNT : 8;
  localparam int IW    = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;
  localparam int CNT_W = $clog2(MAX_CODES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;

  cfg_t             cfg;
  logic [1:0]       state_q, state_d;

  // latched item
  logic             command_q;
  logic [7:0]       elapsed_q;
  logic             rf_valid_q;
  logic [CW-1:0]    code_q;
  logic             button_q;
  logic [SW-1:0]    sensor_q;
  logic             hit_q;

  // panel state
  logic [1:0]       mode_q, mode_d;
  logic [CNT_W-1:0] count_q;
  logic [15:0]      blink_q, blink_d;
  logic             green_q, green_d;
  logic             red_q, red_d;
  logic             siren_q, siren_d;

  // output register
  logic             out_vld_q;
  logic [1:0]       beep_q;
  logic [1:0]       kind_q;
  logic             learned_q;
  logic             full_q;

  logic             in_acc;
  logic             commit;
  logic             search;
  tok_ctl_t         tok_in, tok_out;

  logic [16:0]      blink_sum;
  logic [15:0]      blink_sat;
  logic [15:0]      interval;
  logic             blink_fire;
  logic             sensor_hit;
  logic             room;
  logic             store;
  logic [1:0]       kind, beeps;
  logic             learned, full;

  apc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshakes
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign commit     = (state_q == ST_DONE) & (~out_vld_q | out_o.ready);
  assign search     = ~in_i.command & in_i.rf_valid;

  // search token enters the chain at acceptance
  assign tok_in.vld = in_acc & search;
  assign tok_in.hit = 1'b0;

  apc_chain #(
    .MAX_CODES (MAX_CODES),
    .CW        (CW),
    .IW        (IW),
    .CNT_W     (CNT_W)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tok_i     (tok_in),
    .code_i    (in_i.rf_code[CW-1:0]),
    .tok_o     (tok_out),
    .count_i   (count_q),
    .we_i      (commit & learned),
    .wr_idx_i  (count_q[IW-1:0]),
    .wr_code_i (code_q)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = search ? ST_SEARCH : ST_DONE;
        end
      end
      ST_SEARCH: begin
        if (tok_out.vld) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // blink timer and sensor class
  assign blink_sum  = {1'b0, blink_q} + 17'(elapsed_q);
  assign blink_sat  = blink_sum[16] ? 16'hFFFF : blink_sum[15:0];
  assign interval   = (mode_q == MODE_TRIG) ? cfg.fast_blink_ms : cfg.slow_blink_ms;
  assign blink_fire = blink_sat >= interval;
  assign sensor_hit = |(~sensor_q & cfg.sensor_enable[SW-1:0]);
  assign room       = count_q < CNT_W'(MAX_CODES);

  // mode machine
  always_comb begin
    mode_d  = mode_q;
    blink_d = blink_q;
    green_d = green_q;
    red_d   = red_q;
    siren_d = siren_q;
    kind    = KIND_NONE;
    beeps   = BEEP_NONE;
    store   = 1'b0;
    if (command_q) begin
      store = 1'b1;
    end else begin
      blink_d = blink_sat;
      if (rf_valid_q && hit_q) begin
        kind = KIND_CODE;
      end else if (button_q) begin
        kind = KIND_BUTTON;
      end else if (sensor_hit) begin
        kind = KIND_SENSOR;
      end
      case (mode_q)
        MODE_OFF: begin
          if (kind == KIND_CODE) begin
            green_d = 1'b0;
            siren_d = 1'b0;
            beeps   = BEEP_ARM;
            mode_d  = MODE_ARMED;
          end else if (kind == KIND_BUTTON) begin
            green_d = 1'b0;
            red_d   = 1'b0;
            mode_d  = MODE_LEARN;
          end else if (blink_fire) begin
            blink_d = '0;
            green_d = ~green_q;
          end
        end
        MODE_ARMED: begin
          if (kind == KIND_CODE) begin
            siren_d = 1'b0;
            red_d   = 1'b0;
            beeps   = BEEP_DISARM;
            mode_d  = MODE_OFF;
          end else if (kind == KIND_SENSOR) begin
            siren_d = 1'b1;
            mode_d  = MODE_TRIG;
          end else if (blink_fire) begin
            blink_d = '0;
            red_d   = ~red_q;
          end
        end
        MODE_TRIG: begin
          if (kind == KIND_CODE) begin
            siren_d = 1'b0;
            red_d   = 1'b0;
            beeps   = BEEP_DISARM;
            mode_d  = MODE_OFF;
          end else if (blink_fire) begin
            blink_d = '0;
            red_d   = ~red_q;
          end
        end
        default: begin
          // learning: any received code is appended if there is room, known or not
          if (rf_valid_q) begin
            store   = 1'b1;
            green_d = 1'b0;
            red_d   = 1'b0;
            mode_d  = MODE_OFF;
          end else if (button_q) begin
            mode_d  = MODE_OFF;
          end
        end
      endcase
    end
    learned = store & room;
    full    = store & ~room;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= MODE_OFF;
      count_q   <= '0;
      blink_q   <= '0;
      green_q   <= 1'b0;
      red_q     <= 1'b0;
      siren_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        mode_q    <= mode_d;
        count_q   <= count_q + CNT_W'(learned);
        blink_q   <= blink_d;
        green_q   <= green_d;
        red_q     <= red_d;
        siren_q   <= siren_d;
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // item capture and search result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      command_q  <= in_i.command;
      elapsed_q  <= in_i.elapsed_ms;
      rf_valid_q <= in_i.rf_valid;
      code_q     <= in_i.rf_code[CW-1:0];
      button_q   <= in_i.button_pressed;
      sensor_q   <= in_i.sensor_lines[SW-1:0];
      hit_q      <= 1'b0;
    end else if (state_q == ST_SEARCH && tok_out.vld) begin
      hit_q <= tok_out.hit;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (commit) begin
      beep_q    <= beeps;
      kind_q    <= kind;
      learned_q <= learned;
      full_q    <= full;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.mode         = mode_q;
  assign out_o.green_led    = green_q;
  assign out_o.red_led      = red_q;
  assign out_o.siren        = siren_q;
  assign out_o.beep_count   = beep_q;
  assign out_o.signal_kind  = kind_q;
  assign out_o.code_learned = learned_q;
  assign out_o.table_full   = full_q;

endmodule

/* rtl/core/apc_regs.sv */
// apb configuration registers of the alarm panel
module apc_regs import apc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_enable <= SENSOR_ENABLE_RST;
      cfg_q.slow_blink_ms <= SLOW_BLINK_RST;
      cfg_q.fast_blink_ms <= FAST_BLINK_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SENSOR_ENABLE: cfg_q.sensor_enable <= pwdata[7:0];
        REG_SLOW_BLINK:    cfg_q.slow_blink_ms <= pwdata[15:0];
        REG_FAST_BLINK:    cfg_q.fast_blink_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_SENSOR_ENABLE: prdata = APB_DATA_W'(cfg_q.sensor_enable);
      REG_SLOW_BLINK:    prdata = APB_DATA_W'(cfg_q.slow_blink_ms);
      REG_FAST_BLINK:    prdata = APB_DATA_W'(cfg_q.fast_blink_ms);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/apc_cell.sv */
// one code table entry with its stage of the search token pipeline
module apc_cell import apc_pkg::*; #(
  parameter int CW    = 32,
  parameter int IW    = 4,
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tok_ctl_t         ctl_i,
  input  logic [CW-1:0]    code_i,
  output tok_ctl_t         ctl_o,
  output logic [CW-1:0]    code_o,
  input  logic [CNT_W-1:0] count_i,
  input  logic             we_i,
  input  logic [IW-1:0]    wr_idx_i,
  input  logic [CW-1:0]    wr_code_i
);

  logic [CW-1:0] entry_q;
  logic [CW-1:0] code_q;
  tok_ctl_t      ctl_q;
  logic          in_use;

  // only entries below the fill count take part in the search
  assign in_use = CNT_W'(IDX) < count_i;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (we_i && (wr_idx_i == IW'(IDX))) begin
      entry_q <= wr_code_i;
    end
  end

  // token stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q.vld <= ctl_i.vld;
      ctl_q.hit <= ctl_i.hit | (ctl_i.vld & in_use & (entry_q == code_i));
    end
  end

  // token stage payload
  always_ff @(posedge clk_i) begin
    code_q <= code_i;
  end

  assign ctl_o  = ctl_q;
  assign code_o = code_q;

endmodule

/* rtl/core/apc_chain.sv */
// row of code cells; a search token visits one cell per cycle
module apc_chain import apc_pkg::*; #(
  parameter int MAX_CODES = 16,
  parameter int CW        = 32,
  parameter int IW        = 4,
  parameter int CNT_W     = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tok_ctl_t         tok_i,
  input  logic [CW-1:0]    code_i,
  output tok_ctl_t         tok_o,
  input  logic [CNT_W-1:0] count_i,
  input  logic             we_i,
  input  logic [IW-1:0]    wr_idx_i,
  input  logic [CW-1:0]    wr_code_i
);

  tok_ctl_t      ctl_w  [0:MAX_CODES];
  logic [CW-1:0] code_w [0:MAX_CODES];

  assign ctl_w[0]  = tok_i;
  assign code_w[0] = code_i;

  // cells chained head to tail
  for (genvar k = 0; k < MAX_CODES; k++) begin : g_cell
    apc_cell #(
      .CW    (CW),
      .IW    (IW),
      .CNT_W (CNT_W),
      .IDX   (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl_w[k]),
      .code_i    (code_w[k]),
      .ctl_o     (ctl_w[k+1]),
      .code_o    (code_w[k+1]),
      .count_i   (count_i),
      .we_i      (we_i),
      .wr_idx_i  (wr_idx_i),
      .wr_code_i (wr_code_i)
    );
  end

  assign tok_o = ctl_w[MAX_CODES];

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the alarm panel with remote code learning
module tb_top;
  import apc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         TABLE_DEPTH = 16;
  localparam int         HOLD_CYCLES = 400;
  localparam int         PHASE_ITEMS = 250;
  localparam logic       CMD_POLL    = 1'b0;
  localparam logic       CMD_PRELOAD = 1'b1;
  localparam logic [7:0] LINES_QUIET = 8'hFF;

  typedef struct packed {
    logic        command;
    logic [7:0]  elapsed_ms;
    logic        rf_valid;
    logic [31:0] rf_code;
    logic        button_pressed;
    logic [7:0]  sensor_lines;
  } panel_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       green_led;
    logic       red_led;
    logic       siren;
    logic [1:0] beep_count;
    logic [1:0] signal_kind;
    logic       code_learned;
    logic       table_full;
  } panel_res_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  apc_in_if  in_if ();
  apc_out_if out_if ();

  alarm_panel_with_code_learning_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // panel state as the testbench predicts it
  logic [1:0]   panel_mode    = MODE_OFF;
  logic [31:0]  code_store [TABLE_DEPTH];
  int unsigned  stored_codes  = 0;
  int unsigned  blink_ms      = 0;
  logic         green_lvl     = 1'b0;
  logic         red_lvl       = 1'b0;
  logic         siren_lvl     = 1'b0;
  logic [7:0]   cfg_sensor_en = SENSOR_ENABLE_RST;
  logic [15:0]  cfg_slow_ms   = SLOW_BLINK_RST;
  logic [15:0]  cfg_fast_ms   = FAST_BLINK_RST;

  panel_res_t   pending_results [$];
  int           mismatch_count  = 0;
  int           result_count    = 0;
  bit           calm_tx         = 1'b0;
  bit           calm_rx         = 1'b0;
  bit           hold_req        = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // known values on every input from time zero
  initial begin
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_if.valid          = 1'b0;
    in_if.command        = CMD_POLL;
    in_if.elapsed_ms     = '0;
    in_if.rf_valid       = 1'b0;
    in_if.rf_code        = '0;
    in_if.button_pressed = 1'b0;
    in_if.sensor_lines   = LINES_QUIET;
    out_if.ready         = 1'b0;
  end

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("[%0t] mismatch on result %0d: %s", $realtime, result_count, msg);
    end
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  // predictor helpers
  function automatic bit store_code(logic [31:0] code);
    if (stored_codes >= TABLE_DEPTH) begin
      return 1'b0;
    end
    code_store[stored_codes] = code;
    stored_codes++;
    return 1'b1;
  endfunction

  function automatic bit blink_due(int unsigned interval);
    if (blink_ms >= interval) begin
      blink_ms = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // next panel state and the result item of one accepted input item
  function automatic panel_res_t panel_next(panel_item_t it);
    panel_res_t res;
    logic [1:0] kind;
    bit         known;
    res   = '0;
    kind  = KIND_NONE;
    known = 1'b0;
    if (it.command == CMD_PRELOAD) begin
      if (store_code(it.rf_code)) res.code_learned = 1'b1;
      else res.table_full = 1'b1;
    end else begin
      blink_ms = blink_ms + it.elapsed_ms;
      if (blink_ms > 65535) blink_ms = 65535;
      for (int i = 0; i < stored_codes; i++) begin
        if (code_store[i] == it.rf_code) known = 1'b1;
      end
      // fixed priority: known code, then button, then enabled sensor
      if (it.rf_valid && known) kind = KIND_CODE;
      else if (it.button_pressed) kind = KIND_BUTTON;
      else if ((~it.sensor_lines & cfg_sensor_en) != 8'h00) kind = KIND_SENSOR;

      case (panel_mode)
        MODE_OFF: begin
          if (kind == KIND_CODE) begin
            green_lvl      = 1'b0;
            siren_lvl      = 1'b0;
            res.beep_count = BEEP_ARM;
            panel_mode     = MODE_ARMED;
          end else if (kind == KIND_BUTTON) begin
            green_lvl  = 1'b0;
            red_lvl    = 1'b0;
            panel_mode = MODE_LEARN;
          end else if (blink_due(cfg_slow_ms)) begin
            green_lvl = ~green_lvl;
          end
        end
        MODE_ARMED: begin
          if (kind == KIND_CODE) begin
            siren_lvl      = 1'b0;
            red_lvl        = 1'b0;
            res.beep_count = BEEP_DISARM;
            panel_mode     = MODE_OFF;
          end else if (kind == KIND_SENSOR) begin
            siren_lvl  = 1'b1;
            panel_mode = MODE_TRIG;
          end else if (blink_due(cfg_slow_ms)) begin
            red_lvl = ~red_lvl;
          end
        end
        MODE_TRIG: begin
          if (kind == KIND_CODE) begin
            siren_lvl      = 1'b0;
            red_lvl        = 1'b0;
            res.beep_count = BEEP_DISARM;
            panel_mode     = MODE_OFF;
          end else if (blink_due(cfg_fast_ms)) begin
            red_lvl = ~red_lvl;
          end
        end
        default: begin
          // learning: any received code is appended if there is room, even a known one
          if (it.rf_valid) begin
            if (store_code(it.rf_code)) res.code_learned = 1'b1;
            else res.table_full = 1'b1;
            green_lvl  = 1'b0;
            red_lvl    = 1'b0;
            panel_mode = MODE_OFF;
          end else if (it.button_pressed) begin
            panel_mode = MODE_OFF;
          end
        end
      endcase
    end
    res.mode        = panel_mode;
    res.green_led   = green_lvl;
    res.red_led     = red_lvl;
    res.siren       = siren_lvl;
    res.signal_kind = kind;
    return res;
  endfunction

  // item builders
  function automatic panel_item_t poll(logic [7:0] elapsed, logic rf_vld, logic [31:0] code,
                                       logic button, logic [7:0] lines);
    return '{CMD_POLL, elapsed, rf_vld, code, button, lines};
  endfunction

  function automatic panel_item_t preload(logic [31:0] code);
    return '{CMD_PRELOAD, 8'($urandom), 1'($urandom), code, 1'($urandom), 8'($urandom)};
  endfunction

  // random item shaped by the predicted mode, reusing stored codes often
  function automatic panel_item_t random_item();
    panel_item_t it;
    int unsigned rf_pct;
    it = '{CMD_POLL, 8'($urandom), 1'b0, $urandom, 1'b0, LINES_QUIET};
    if ($urandom_range(0, 99) < 10) it.elapsed_ms = 8'd0;
    if (stored_codes > 0 && $urandom_range(0, 99) < 70) begin
      it.rf_code = code_store[$urandom_range(0, stored_codes - 1)];
    end
    if ($urandom_range(0, 99) < 2) begin
      it.command = CMD_PRELOAD;
      return it;
    end
    rf_pct            = (panel_mode == MODE_LEARN) ? 45 : 25;
    it.rf_valid       = ($urandom_range(0, 99) < rf_pct);
    it.button_pressed = ($urandom_range(0, 99) < 8);
    if ($urandom_range(0, 99) < 30) it.sensor_lines = 8'($urandom);
    return it;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (calm_tx) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 100);
  endfunction

  // offer one item, wait for it to be taken, then record its expected result
  task automatic send_item(panel_item_t it);
    int gap;
    gap = pick_gap();
    in_if.valid          <= 1'b1;
    in_if.command        <= it.command;
    in_if.elapsed_ms     <= it.elapsed_ms;
    in_if.rf_valid       <= it.rf_valid;
    in_if.rf_code        <= it.rf_code;
    in_if.button_pressed <= it.button_pressed;
    in_if.sensor_lines   <= it.sensor_lines;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    pending_results.push_back(panel_next(it));
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering items and wait for every outstanding result
  task automatic drain();
    if (in_if.valid !== 1'b0) in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // apb write followed by a read back of the same register
  task automatic set_register(logic [1:0] idx, logic [15:0] value);
    logic [31:0] want;
    logic [31:0] got;
    want = (idx == REG_SENSOR_ENABLE) ? {24'h0, value[7:0]} : {16'h0, value};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= want;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SENSOR_ENABLE: cfg_sensor_en = want[7:0];
      REG_SLOW_BLINK:    cfg_slow_ms   = want[15:0];
      default:           cfg_fast_ms   = want[15:0];
    endcase
    if (got !== want) begin
      report_mismatch($sformatf("register %0d read back %0h want %0h", idx, got, want));
    end
    // bus idle before the next transfer
    @(posedge clk_i);
  endtask

  task automatic configure(logic [7:0] sensor_en, logic [15:0] slow_ms, logic [15:0] fast_ms);
    drain();
    set_register(REG_SENSOR_ENABLE, {8'h00, sensor_en});
    set_register(REG_SLOW_BLINK, slow_ms);
    set_register(REG_FAST_BLINK, fast_ms);
  endtask

  // receiver: random ready runs, calm stretches and one long hold-off
  initial begin
    int run_left;
    int hold_left;
    int unsigned r;
    run_left  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if (calm_rx) begin
        out_if.ready <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
      end else if ($urandom_range(0, 99) < 65) begin
        out_if.ready <= 1'b1;
        run_left = $urandom_range(0, 15);
      end else begin
        out_if.ready <= 1'b0;
        r = $urandom_range(0, 99);
        if (r < 80) run_left = $urandom_range(0, 2);
        else if (r < 97) run_left = $urandom_range(3, 14);
        else run_left = $urandom_range(30, 100);
      end
    end
  end

  // compare each result item with the oldest prediction
  always @(posedge clk_i) begin
    panel_res_t got;
    panel_res_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = '{out_if.mode, out_if.green_led, out_if.red_led, out_if.siren, out_if.beep_count,
              out_if.signal_kind, out_if.code_learned, out_if.table_full};
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("mode", got.mode, want.mode);
        check_field("green_led", got.green_led, want.green_led);
        check_field("red_led", got.red_led, want.red_led);
        check_field("siren", got.siren, want.siren);
        check_field("beep_count", got.beep_count, want.beep_count);
        check_field("signal_kind", got.signal_kind, want.signal_kind);
        check_field("code_learned", got.code_learned, want.code_learned);
        check_field("table_full", got.table_full, want.table_full);
      end
    end
  end

  // arm, button over sensor, unknown code, trigger, fast blink, disarm
  task automatic test_preload_and_arming();
    send_item(preload(32'hA5A5_0001));
    send_item(poll(8'd0, 1'b1, 32'hA5A5_0001, 1'b0, LINES_QUIET));
    send_item(poll(8'd100, 1'b0, 32'h0, 1'b1, 8'hFE));
    send_item(poll(8'd50, 1'b1, 32'h1234_5678, 1'b0, LINES_QUIET));
    send_item(poll(8'd255, 1'b0, 32'h0, 1'b0, 8'hFE));
    send_item(poll(8'd255, 1'b0, 32'h0, 1'b0, LINES_QUIET));
    send_item(poll(8'd10, 1'b1, 32'hA5A5_0001, 1'b0, LINES_QUIET));
    drain();
  endtask

  // learning a new code, leaving by button, learning a duplicate
  task automatic test_learning();
    send_item(poll(8'd0, 1'b0, 32'h0, 1'b1, LINES_QUIET));
    send_item(poll(8'd0, 1'b1, 32'h5A5A_0002, 1'b0, LINES_QUIET));
    send_item(poll(8'd0, 1'b0, 32'h0, 1'b1, 8'h00));
    send_item(poll(8'd0, 1'b0, 32'h0, 1'b1, LINES_QUIET));
    send_item(poll(8'd0, 1'b0, 32'h0, 1'b1, LINES_QUIET));
    send_item(poll(8'd0, 1'b1, 32'hA5A5_0001, 1'b0, LINES_QUIET));
    send_item(poll(8'd0, 1'b1, 32'h5A5A_0002, 1'b0, LINES_QUIET));
    send_item(poll(8'd0, 1'b1, 32'h5A5A_0002, 1'b0, LINES_QUIET));
    drain();
  endtask

  // all-zero and all-one codes and lines, shortest and longest elapsed time
  task automatic test_field_extremes();
    send_item(preload(32'h0000_0000));
    send_item(preload(32'hFFFF_FFFF));
    send_item(poll(8'd255, 1'b1, 32'hFFFF_FFFF, 1'b0, 8'h00));
    send_item(poll(8'd0, 1'b1, 32'h0000_0000, 1'b0, LINES_QUIET));
    drain();
  endtask

  // a zero blink interval toggles on every blinking poll
  task automatic test_zero_interval();
    configure(8'hFF, 16'd0, 16'd0);
    send_item(poll(8'd0, 1'b0, 32'h0, 1'b0, LINES_QUIET));
    send_item(poll(8'd0, 1'b0, 32'h0, 1'b0, LINES_QUIET));
    send_item(poll(8'd0, 1'b1, 32'hA5A5_0001, 1'b0, LINES_QUIET));
    send_item(poll(8'd0, 1'b0, 32'h0, 1'b0, LINES_QUIET));
    send_item(poll(8'd0, 1'b0, 32'h0, 1'b0, 8'h7F));
    send_item(poll(8'd0, 1'b0, 32'h0, 1'b0, LINES_QUIET));
    send_item(poll(8'd0, 1'b1, 32'hA5A5_0001, 1'b0, LINES_QUIET));
    drain();
  endtask

  // blink timer saturates while learning and then meets the longest interval
  task automatic test_timer_saturation();
    configure(8'h01, 16'hFFFF, 16'hFFFF);
    send_item(poll(8'd0, 1'b0, 32'h0, 1'b1, LINES_QUIET));
    repeat (300) begin
      send_item(poll(8'($urandom_range(220, 255)), 1'b0, $urandom, 1'b0, 8'($urandom)));
    end
    send_item(poll(8'd0, 1'b0, 32'h0, 1'b1, LINES_QUIET));
    send_item(poll(8'd0, 1'b0, 32'h0, 1'b0, LINES_QUIET));
    drain();
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    calm_tx  = 1'b1;
    hold_req = 1'b1;
    repeat (40) send_item(random_item());
    calm_tx = 1'b0;
    drain();
  endtask

  // random items over several register settings, the extremes among them
  task automatic test_random_phases();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       configure(8'hFF, 16'd1, 16'd1);
        1:       configure(8'h00, 16'hFFFF, 16'hFFFF);
        2:       configure(8'h80, SLOW_BLINK_RST, FAST_BLINK_RST);
        default: configure(8'($urandom), 16'($urandom_range(1, 2000)),
                           16'($urandom_range(1, 600)));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) begin
          calm_tx = ($urandom_range(0, 5) == 0);
          calm_rx = calm_tx;
        end
        send_item(random_item());
      end
      calm_tx = 1'b0;
      calm_rx = 1'b0;
    end
    drain();
  endtask

  // reset, tests in turn, final verdict
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_preload_and_arming();
    test_learning();
    test_field_extremes();
    test_zero_interval();
    test_timer_saturation();
    test_backpressure();
    test_random_phases();
    drain();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #25_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/core/apc_pkg.sv
rtl/core/apc_if.sv
rtl/core/apc_regs.sv
rtl/core/apc_cell.sv
rtl/core/apc_chain.sv
rtl/core/alarm_panel_with_code_learning_top.sv
tb/tb_top.sv
